// File: hw/rtl/wcse_pkg.sv
// Shared types and constants for the WebAssembly custom section extractor.
// No dependencies; used by wcse_core and wasm_custom_section_extractor.
`timescale 1ns / 1ps

package wcse_pkg;

	localparam int HEADER_BYTES   = 8;   // module magic + version, skipped unchecked
	localparam int HDR_CNT_W      = 4;
	localparam int NAME_MAX_BYTES = 8;
	localparam int NAME_IDX_W     = 4;
	localparam int NAME_LEN_W     = 4;
	localparam int NAME_BITS      = 64;
	localparam int LEB_DATA_BITS  = 7;
	localparam int LEB_MAX_SHIFT  = 63;
	localparam int LEB_SHIFT_W    = 6;

	typedef enum logic [1:0] {
		ST_PROGRESS  = 2'd0,
		ST_FOUND     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_BAD       = 2'd3
	} status_t;

	// one result beat from the parser
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       is_payload;
		logic       final_item;
		status_t    status;
	} res_t;

endpackage

// File: hw/rtl/wasm_custom_section_extractor.sv
// Top level: stream ports, configuration registers, input and result registers.
// Depends on wcse_pkg and wcse_core.
`timescale 1ns / 1ps

// Path: each accepted byte goes through the input register, then the result
//   register, before its result beat shows on m_*; while the result register
//   is held, the byte waits in the input register.
// Throughput: one module byte per cycle; only the result register backpressures.
// Reset (arst_n low, async): parse state to header phase, no beats held,
//   target_name = 0, target_name_length = 7. Payload data regs are not reset.
module wasm_custom_section_extractor #(
	parameter int LENGTH_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] module_byte
	input  logic        s_tlast,   // end_of_module
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] payload_byte, [9:8] scan_status, rest zero
	output logic        m_tlast,   // final_item
	output logic        m_tuser,   // is_payload
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [63:0] cfg_wdata
);

	localparam logic REG_TARGET_NAME = 1'b0;
	localparam logic REG_TARGET_LEN  = 1'b1;

	// config registers
	logic [wcse_pkg::NAME_BITS-1:0]  target_name_q;
	logic [wcse_pkg::NAME_LEN_W-1:0] target_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_name_q <= '0;
			target_len_q  <= wcse_pkg::NAME_LEN_W'(7);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_TARGET_NAME: target_name_q <= cfg_wdata;
				REG_TARGET_LEN:  target_len_q  <= cfg_wdata[wcse_pkg::NAME_LEN_W-1:0];
				default:         target_name_q <= target_name_q;
			endcase
		end
	end

	// input register
	logic       in_valid_s1;
	logic [7:0] in_byte_s1;
	logic       in_last_s1;

	// result register
	logic              out_valid_s2;
	logic [7:0]        out_data_s2;
	logic              out_payload_s2;
	logic              out_last_s2;
	wcse_pkg::status_t out_status_s2;

	wcse_pkg::res_t res;
	logic           adv;

	// the held byte moves on once the result slot is free or draining
	assign adv      = in_valid_s1 && (!out_valid_s2 || m_tready);
	assign s_tready = !in_valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_byte_s1 <= s_tdata;
			in_last_s1 <= s_tlast;
		end
	end

	wcse_core #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (adv),
		.module_byte       (in_byte_s1),
		.end_of_module     (in_last_s1),
		.target_name       (target_name_q),
		.target_name_length(target_len_q),
		.res               (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= res.valid;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			out_data_s2    <= res.data;
			out_payload_s2 <= res.is_payload;
			out_last_s2    <= res.final_item;
			out_status_s2  <= res.status;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {6'd0, out_status_s2, out_data_s2};
	assign m_tlast  = out_last_s2;
	assign m_tuser  = out_payload_s2;

	// a beat without payload exists only for the last byte
	a_nopay_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("non-payload beat that is not final");

	a_status_mid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[9:8] == wcse_pkg::ST_PROGRESS)
		else $error("status reported before the last byte");

	a_nopay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
		else $error("data on a beat without payload");

endmodule

// File: hw/rtl/wcse_core.sv
// Section parser: parse state registers and the per-byte next-state logic.
// Depends on wcse_pkg.
`timescale 1ns / 1ps

module wcse_core #(
	parameter int LENGTH_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  logic [7:0]                      module_byte,
	input  logic                            end_of_module,
	input  logic [wcse_pkg::NAME_BITS-1:0]  target_name,
	input  logic [wcse_pkg::NAME_LEN_W-1:0] target_name_length,
	output wcse_pkg::res_t                  res
);

	localparam int WIDE_W = wcse_pkg::LEB_DATA_BITS + wcse_pkg::LEB_MAX_SHIFT;

	typedef enum logic [2:0] {
		PH_HEADER     = 3'd0,
		PH_ID         = 3'd1,
		PH_LEN_CUSTOM = 3'd2,
		PH_LEN_OTHER  = 3'd3,
		PH_NAME_LEN   = 3'd4,
		PH_NAME       = 3'd5,
		PH_PAYLOAD    = 3'd6,
		PH_SKIP       = 3'd7
	} phase_t;

	phase_t                              phase_q, phase_d;
	logic [wcse_pkg::HDR_CNT_W-1:0]      hdr_cnt_q, hdr_cnt_d;
	logic [LENGTH_BITS-1:0]              acc_q, acc_d;
	logic [wcse_pkg::LEB_SHIFT_W-1:0]    shift_q, shift_d;
	logic [LENGTH_BITS-1:0]              sec_rem_q, sec_rem_d;
	logic [LENGTH_BITS-1:0]              name_rem_q, name_rem_d;
	logic [wcse_pkg::NAME_IDX_W-1:0]     name_idx_q, name_idx_d;
	logic                                match_q, match_d;
	wcse_pkg::status_t                   outcome_q, outcome_d;

	// ULEB128 byte step
	logic [WIDE_W-1:0]                   leb_wide;
	logic [LENGTH_BITS-1:0]              leb_acc;
	logic [wcse_pkg::LEB_SHIFT_W:0]      leb_shift_sum;
	logic                                leb_err;
	logic                                leb_done;

	always_comb begin
		leb_wide      = WIDE_W'(module_byte[6:0]) << shift_q;
		leb_acc       = acc_q | leb_wide[LENGTH_BITS-1:0];
		leb_shift_sum = {1'b0, shift_q} + (wcse_pkg::LEB_SHIFT_W+1)'(wcse_pkg::LEB_DATA_BITS);
		leb_done      = !module_byte[7];
		// value bit past the counter width, or shift beyond 63
		leb_err       = (|leb_wide[WIDE_W-1:LENGTH_BITS]) ||
			(module_byte[7] &&
			 (leb_shift_sum > (wcse_pkg::LEB_SHIFT_W+1)'(wcse_pkg::LEB_MAX_SHIFT)));
	end

	logic [LENGTH_BITS-1:0]         sec_dec;
	logic [LENGTH_BITS-1:0]         name_dec;
	logic                           name_ok_len;
	logic                           byte_match;
	logic                           match_new;
	logic                           emit;
	logic [wcse_pkg::HDR_CNT_W-1:0] hdr_inc;

	always_comb begin
		sec_dec     = sec_rem_q - LENGTH_BITS'(1);
		name_dec    = name_rem_q - LENGTH_BITS'(1);
		hdr_inc     = hdr_cnt_q + wcse_pkg::HDR_CNT_W'(1);
		name_ok_len = (target_name_length <= wcse_pkg::NAME_LEN_W'(wcse_pkg::NAME_MAX_BYTES)) &&
			(leb_acc == LENGTH_BITS'(target_name_length));
		byte_match  = !name_idx_q[wcse_pkg::NAME_IDX_W-1] &&
			(target_name[{name_idx_q[2:0], 3'b000} +: 8] == module_byte);
		match_new   = match_q && byte_match;

		phase_d    = phase_q;
		hdr_cnt_d  = hdr_cnt_q;
		acc_d      = acc_q;
		shift_d    = shift_q;
		sec_rem_d  = sec_rem_q;
		name_rem_d = name_rem_q;
		name_idx_d = name_idx_q;
		match_d    = match_q;
		outcome_d  = outcome_q;
		emit       = 1'b0;

		if (step && outcome_q == wcse_pkg::ST_PROGRESS) begin
			case (phase_q)
				PH_HEADER: begin
					hdr_cnt_d = hdr_inc;
					if (hdr_inc >= wcse_pkg::HDR_CNT_W'(wcse_pkg::HEADER_BYTES)) begin
						phase_d = PH_ID;
					end
				end
				PH_ID: begin
					acc_d   = '0;
					shift_d = '0;
					phase_d = (module_byte == 8'd0) ? PH_LEN_CUSTOM : PH_LEN_OTHER;
				end
				PH_LEN_CUSTOM, PH_LEN_OTHER: begin
					if (leb_err) begin
						outcome_d = wcse_pkg::ST_BAD;
					end else if (!leb_done) begin
						acc_d   = leb_acc;
						shift_d = leb_shift_sum[wcse_pkg::LEB_SHIFT_W-1:0];
					end else begin
						sec_rem_d = leb_acc;
						if (phase_q == PH_LEN_CUSTOM) begin
							acc_d   = '0;
							shift_d = '0;
							phase_d = PH_NAME_LEN;
						end else begin
							acc_d   = leb_acc;
							phase_d = (leb_acc == '0) ? PH_ID : PH_SKIP;
						end
					end
				end
				PH_NAME_LEN: begin
					if (sec_rem_q == '0) begin
						outcome_d = wcse_pkg::ST_BAD;
					end else begin
						sec_rem_d = sec_dec;
						if (leb_err) begin
							outcome_d = wcse_pkg::ST_BAD;
						end else if (!leb_done) begin
							acc_d   = leb_acc;
							shift_d = leb_shift_sum[wcse_pkg::LEB_SHIFT_W-1:0];
						end else if (leb_acc > sec_dec) begin
							outcome_d = wcse_pkg::ST_BAD;
						end else begin
							acc_d      = leb_acc;
							name_rem_d = leb_acc;
							name_idx_d = '0;
							match_d    = name_ok_len;
							if (leb_acc != '0) begin
								phase_d = PH_NAME;
							end else if (name_ok_len) begin
								if (sec_dec == '0) outcome_d = wcse_pkg::ST_FOUND;
								else               phase_d   = PH_PAYLOAD;
							end else begin
								phase_d = (sec_dec == '0) ? PH_ID : PH_SKIP;
							end
						end
					end
				end
				PH_NAME: begin
					match_d = match_new;
					if (!name_idx_q[wcse_pkg::NAME_IDX_W-1]) begin
						name_idx_d = name_idx_q + wcse_pkg::NAME_IDX_W'(1);
					end
					sec_rem_d  = sec_dec;
					name_rem_d = name_dec;
					if (name_dec == '0) begin
						if (match_new) begin
							if (sec_dec == '0) outcome_d = wcse_pkg::ST_FOUND;
							else               phase_d   = PH_PAYLOAD;
						end else begin
							phase_d = (sec_dec == '0) ? PH_ID : PH_SKIP;
						end
					end
				end
				PH_PAYLOAD: begin
					emit      = 1'b1;
					sec_rem_d = sec_dec;
					if (sec_dec == '0) outcome_d = wcse_pkg::ST_FOUND;
				end
				PH_SKIP: begin
					sec_rem_d = sec_dec;
					if (sec_dec == '0) phase_d = PH_ID;
				end
				default: begin
					phase_d = PH_HEADER;
				end
			endcase
		end

		res.valid      = step && (emit || end_of_module);
		res.data       = emit ? module_byte : 8'd0;
		res.is_payload = emit;
		res.final_item = end_of_module;
		res.status     = wcse_pkg::ST_PROGRESS;
		if (end_of_module) begin
			if (outcome_d != wcse_pkg::ST_PROGRESS) res.status = outcome_d;
			else if (phase_d == PH_ID)              res.status = wcse_pkg::ST_NOT_FOUND;
			else                                    res.status = wcse_pkg::ST_BAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hdr_cnt_q  <= '0;
			acc_q      <= '0;
			shift_q    <= '0;
			sec_rem_q  <= '0;
			name_rem_q <= '0;
			name_idx_q <= '0;
			match_q    <= 1'b1;
			outcome_q  <= wcse_pkg::ST_PROGRESS;
		end else if (step && end_of_module) begin
			// last byte: back to reset parse state for the next module
			phase_q    <= PH_HEADER;
			hdr_cnt_q  <= '0;
			acc_q      <= '0;
			shift_q    <= '0;
			sec_rem_q  <= '0;
			name_rem_q <= '0;
			name_idx_q <= '0;
			match_q    <= 1'b1;
			outcome_q  <= wcse_pkg::ST_PROGRESS;
		end else begin
			phase_q    <= phase_d;
			hdr_cnt_q  <= hdr_cnt_d;
			acc_q      <= acc_d;
			shift_q    <= shift_d;
			sec_rem_q  <= sec_rem_d;
			name_rem_q <= name_rem_d;
			name_idx_q <= name_idx_d;
			match_q    <= match_d;
			outcome_q  <= outcome_d;
		end
	end

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && end_of_module |=> phase_q == PH_HEADER && outcome_q == wcse_pkg::ST_PROGRESS)
		else $error("parse state not cleared after last byte");

	a_hdr_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_cnt_q <= wcse_pkg::HDR_CNT_W'(wcse_pkg::HEADER_BYTES))
		else $error("header count past header length");

	a_body_left: assert property (@(posedge clk) disable iff (!arst_n)
		outcome_q == wcse_pkg::ST_PROGRESS && (phase_q == PH_PAYLOAD || phase_q == PH_SKIP)
		|-> sec_rem_q != '0)
		else $error("in section body with nothing left");

endmodule
